// ----- hdl/nsc_pkg.sv -----
// nsc_pkg: types, character codes and tag tables of the nmea sentence checker
package nsc_pkg;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 5;
   localparam int TAIL_W = 6;
   localparam int KIND_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_STAR = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_0    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;

   localparam logic [POS_W-1:0]  POS_MAX   = 5'd31;
   localparam logic [POS_W-1:0]  TAG_START = 5'd3;
   localparam logic [POS_W-1:0]  SHORT_END = 5'd5;
   localparam logic [POS_W-1:0]  TXT_END   = 5'd14;
   localparam logic [TAIL_W-1:0] TAIL_MAX  = 6'd32;

   localparam logic [CHAR_W-1:0] TAG_RMC [3]  = '{8'h52, 8'h4D, 8'h43};
   localparam logic [CHAR_W-1:0] TAG_GGA [3]  = '{8'h47, 8'h47, 8'h41};
   localparam logic [CHAR_W-1:0] TAG_GSV [3]  = '{8'h47, 8'h53, 8'h56};
   localparam logic [CHAR_W-1:0] TAG_TXT [12] = '{8'h54, 8'h58, 8'h54, 8'h2C,
                                                  8'h30, 8'h32, 8'h2C, 8'h30,
                                                  8'h31, 8'h2C, 8'h30, 8'h32};

   typedef enum logic [KIND_W-1:0] {
      KIND_OTHER = 3'd0,
      KIND_RMC   = 3'd1,
      KIND_GGA   = 3'd2,
      KIND_GSV   = 3'd3,
      KIND_TXT   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              last_char;
   } word_type;

   typedef struct packed {
      kind_type          sentence_kind;
      logic              checksum_ok;
      logic [CHAR_W-1:0] xor_sum;
   } result_type;

endpackage

// ----- hdl/nsc_in_stage.sv -----
// nsc_in_stage: input register that holds one accepted word until the parser takes it
module nsc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  nsc_pkg::word_type in_word,
   input  logic             out_free,
   output logic             step,
   output nsc_pkg::word_type word
);
   import nsc_pkg::*;

   logic     valid_ff, valid_in;
   word_type word_ff, word_in;
   logic     advance;

   assign advance  = valid_ff && (!word_ff.last_char || out_free);
   assign in_ready = !valid_ff || advance;
   assign step     = advance;
   assign word     = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         word_in  = in_word;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

endmodule

// ----- hdl/nsc_parser.sv -----
// nsc_parser: per-sentence state, checksum and kind tracking, result on the last word
module nsc_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  nsc_pkg::word_type  word,
   output logic               res_load,
   output nsc_pkg::result_type result
);
   import nsc_pkg::*;

   logic [POS_W-1:0]  byte_pos_ff, byte_pos_in;
   logic [CHAR_W-1:0] xor_acc_ff, xor_acc_in;
   logic              star_seen_ff, star_seen_in;
   logic [TAIL_W-1:0] tail_count_ff, tail_count_in;
   logic [CHAR_W-1:0] hex_value_ff, hex_value_in;
   logic              hex_overflow_ff, hex_overflow_in;
   logic              line_end_seen_ff, line_end_seen_in;
   logic              bad_hex_ff, bad_hex_in;
   logic [3:0]        kind_match_ff, kind_match_in;

   logic [CHAR_W-1:0] c;
   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  rel;
   logic              in_short, in_txt;
   logic [3:0]        hit;
   logic              is_digit, is_alpha;
   logic [3:0]        digit;
   logic [3:0]        km;
   logic [CHAR_W-1:0] xa;
   logic              ss, les, bh, ho;
   logic [TAIL_W-1:0] tc;
   logic [CHAR_W-1:0] hv;
   kind_type          kind;
   logic              ok;

   assign c        = word.char_byte;
   assign pos      = byte_pos_ff;
   assign rel      = pos - TAG_START;
   assign in_short = (pos >= TAG_START) && (pos <= SHORT_END);
   assign in_txt   = (pos >= TAG_START) && (pos < TXT_END + 5'd1);
   assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
   assign is_alpha = (c >= CHAR_A) && (c <= CHAR_F);

   always_comb begin
      hit[0] = !in_short || (c == TAG_RMC[rel[1:0]]);
      hit[1] = !in_short || (c == TAG_GGA[rel[1:0]]);
      hit[2] = !in_short || (c == TAG_GSV[rel[1:0]]);
      hit[3] = !in_txt   || (c == TAG_TXT[rel[3:0]]);
      if (is_digit) begin
         digit = 4'(c - CHAR_0);
      end else begin
         digit = 4'(c - CHAR_A + 8'd10);
      end
   end

   always_comb begin
      km  = kind_match_ff & hit;
      xa  = xor_acc_ff;
      ss  = star_seen_ff;
      tc  = tail_count_ff;
      les = line_end_seen_ff;
      bh  = bad_hex_ff;
      ho  = hex_overflow_ff;
      hv  = hex_value_ff;
      if (star_seen_ff) begin
         if (tail_count_ff < TAIL_MAX) begin
            tc = tail_count_ff + 6'd1;
         end
         if (!line_end_seen_ff) begin
            if (c == CHAR_CR || c == CHAR_LF) begin
               les = 1'b1;
            end else if (!is_digit && !is_alpha) begin
               bh = 1'b1;
            end else begin
               if (hex_value_ff > 8'd15) begin
                  ho = 1'b1;
               end
               hv = {hex_value_ff[3:0], digit};
            end
         end
      end else if (pos >= 5'd2 && c == CHAR_STAR) begin
         ss = 1'b1;
      end else if (pos >= 5'd1) begin
         xa = xor_acc_ff ^ c;
      end
   end

   always_comb begin
      priority if (km[0] && pos >= SHORT_END) begin
         kind = KIND_RMC;
      end else if (km[1] && pos >= SHORT_END) begin
         kind = KIND_GGA;
      end else if (km[2] && pos >= SHORT_END) begin
         kind = KIND_GSV;
      end else if (km[3] && pos >= TXT_END) begin
         kind = KIND_TXT;
      end else begin
         kind = KIND_OTHER;
      end
      ok = (pos >= 5'd2) && ss && (tc >= 6'd1) && (tc < TAIL_MAX) && !bh && !ho && (hv == xa);
   end

   assign res_load             = step && word.last_char;
   assign result.sentence_kind = kind;
   assign result.checksum_ok   = ok;
   assign result.xor_sum       = xa;

   always_comb begin
      byte_pos_in      = byte_pos_ff;
      xor_acc_in       = xor_acc_ff;
      star_seen_in     = star_seen_ff;
      tail_count_in    = tail_count_ff;
      hex_value_in     = hex_value_ff;
      hex_overflow_in  = hex_overflow_ff;
      line_end_seen_in = line_end_seen_ff;
      bad_hex_in       = bad_hex_ff;
      kind_match_in    = kind_match_ff;
      if (step) begin
         if (word.last_char) begin
            byte_pos_in      = '0;
            xor_acc_in       = '0;
            star_seen_in     = 1'b0;
            tail_count_in    = '0;
            hex_value_in     = '0;
            hex_overflow_in  = 1'b0;
            line_end_seen_in = 1'b0;
            bad_hex_in       = 1'b0;
            kind_match_in    = '1;
         end else begin
            byte_pos_in      = (byte_pos_ff < POS_MAX) ? byte_pos_ff + 5'd1 : byte_pos_ff;
            xor_acc_in       = xa;
            star_seen_in     = ss;
            tail_count_in    = tc;
            hex_value_in     = hv;
            hex_overflow_in  = ho;
            line_end_seen_in = les;
            bad_hex_in       = bh;
            kind_match_in    = km;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff      <= '0;
         xor_acc_ff       <= '0;
         star_seen_ff     <= 1'b0;
         tail_count_ff    <= '0;
         hex_value_ff     <= '0;
         hex_overflow_ff  <= 1'b0;
         line_end_seen_ff <= 1'b0;
         bad_hex_ff       <= 1'b0;
         kind_match_ff    <= '1;
      end else begin
         byte_pos_ff      <= byte_pos_in;
         xor_acc_ff       <= xor_acc_in;
         star_seen_ff     <= star_seen_in;
         tail_count_ff    <= tail_count_in;
         hex_value_ff     <= hex_value_in;
         hex_overflow_ff  <= hex_overflow_in;
         line_end_seen_ff <= line_end_seen_in;
         bad_hex_ff       <= bad_hex_in;
         kind_match_ff    <= kind_match_in;
      end
   end

endmodule

// ----- hdl/nsc_out_stage.sv -----
// nsc_out_stage: result register that holds one result word until the sink takes it
module nsc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_load,
   input  nsc_pkg::result_type result,
   output logic                out_free,
   output logic                out_valid,
   input  logic                out_ready,
   output nsc_pkg::result_type out_result
);
   import nsc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign out_free   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (res_load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

endmodule

// ----- hdl/nmea_sentence_check_unit.sv -----
// nmea_sentence_check_unit: top level of the nmea sentence kind and checksum checker
//
//   channel  dir  tdata                               tuser
//   req_     in   [7:0] char_byte                     -       tlast = last_char
//   rsp_     out  [0] checksum_ok, [8:1] xor_sum      [2:0] sentence_kind
//
// one word per cycle, except while a last word waits in the input register on a stalled result
// a result passes from the input register through the parser into the result register
// synchronous reset clears the handshake valids and the per-sentence state
// a stalled result holds only a last word in the input register; other words keep flowing
module nmea_sentence_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] checksum_ok, [8:1] xor_sum, rest zero
   output logic [2:0]  rsp_tuser    // [2:0] sentence_kind
);
   import nsc_pkg::*;

   word_type   in_word, word;
   result_type result, out_result;
   logic       step, res_load, out_free;

   assign in_word.char_byte = req_tdata;
   assign in_word.last_char = req_tlast;

   nsc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (in_word),
      .out_free (out_free),
      .step     (step),
      .word     (word)
   );

   nsc_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .word     (word),
      .res_load (res_load),
      .result   (result)
   );

   nsc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_load   (res_load),
      .result     (result),
      .out_free   (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {7'd0, out_result.xor_sum, out_result.checksum_ok};
   assign rsp_tuser = out_result.sentence_kind;

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for the nmea sentence kind and checksum checker
`timescale 1ns / 1ps

module tb_top;
   import nsc_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      bit         typed;
      result_type want;
   } word_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_byte
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [0] checksum_ok, [8:1] xor_sum, rest zero
   logic [2:0]  rsp_tuser;            // [2:0] sentence_kind

   result_type   awaited_verdicts[$];
   word_row_type directed_words[$];
   logic [7:0]   line_buf[$];
   bit           check_failed = 1'b0;

   // checker shadow of the per-sentence state
   int         pos_idx;
   logic [7:0] running_xor;
   bit         star_found;
   int         tail_len;
   logic [7:0] hex_acc;
   bit         hex_too_big;
   bit         eol_found;
   bit         hex_bad;
   logic [3:0] tag_alive;

   nmea_sentence_check_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic clear_sentence_state();
      pos_idx     = 0;
      running_xor = 8'h00;
      star_found  = 1'b0;
      tail_len    = 0;
      hex_acc     = 8'h00;
      hex_too_big = 1'b0;
      eol_found   = 1'b0;
      hex_bad     = 1'b0;
      tag_alive   = 4'hF;
   endtask

   task automatic scan_sentence_char(input logic [7:0] c, input logic is_last,
                                     output bit emitted, output result_type verdict);
      int         p;
      logic [3:0] nib;
      bit         is_hex;
      kind_type   kind;
      p = pos_idx;
      if (p >= 3 && p < 6) begin
         if (c != TAG_RMC[p-3]) tag_alive[0] = 1'b0;
         if (c != TAG_GGA[p-3]) tag_alive[1] = 1'b0;
         if (c != TAG_GSV[p-3]) tag_alive[2] = 1'b0;
      end
      if (p >= 3 && p < 15) begin
         if (c != TAG_TXT[p-3]) tag_alive[3] = 1'b0;
      end
      if (star_found) begin
         if (tail_len < 32) tail_len++;
         if (!eol_found) begin
            if (c == CHAR_CR || c == CHAR_LF) begin
               eol_found = 1'b1;
            end else begin
               is_hex = 1'b1;
               nib    = 4'h0;
               if (c >= CHAR_0 && c <= CHAR_9) begin
                  nib = 4'(c - CHAR_0);
               end else if (c >= CHAR_A && c <= CHAR_F) begin
                  nib = 4'(c - CHAR_A + 8'd10);
               end else begin
                  is_hex = 1'b0;
               end
               if (!is_hex) begin
                  hex_bad = 1'b1;
               end else begin
                  if (hex_acc > 8'd15) hex_too_big = 1'b1;
                  hex_acc = {hex_acc[3:0], nib};
               end
            end
         end
      end else if (p >= 2 && c == CHAR_STAR) begin
         star_found = 1'b1;
      end else if (p >= 1) begin
         running_xor ^= c;
      end
      if (pos_idx < 31) pos_idx++;
      emitted = is_last;
      verdict = '0;
      if (is_last) begin
         kind = KIND_OTHER;
         if (tag_alive[0] && p >= 5) kind = KIND_RMC;
         else if (tag_alive[1] && p >= 5) kind = KIND_GGA;
         else if (tag_alive[2] && p >= 5) kind = KIND_GSV;
         else if (tag_alive[3] && p >= 14) kind = KIND_TXT;
         verdict.sentence_kind = kind;
         verdict.checksum_ok   = p >= 2 && star_found && tail_len >= 1 && tail_len < 32 &&
                                 !hex_bad && !hex_too_big && hex_acc == running_xor;
         verdict.xor_sum       = running_xor;
         clear_sentence_state();
      end
   endtask

   task automatic offer_word(input logic [7:0] c, input logic l, input bit typed,
                             input result_type want, input int gap, input bit drain);
      bit         emitted;
      result_type predicted;
      if (gap > 0 || drain) begin
         req_tvalid <= 1'b0;
         if (drain) begin
            do @(posedge clock); while (awaited_verdicts.size() != 0);
         end
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= l;
      do @(posedge clock); while (!(req_tvalid && req_tready === 1'b1));
      scan_sentence_char(c, l, emitted, predicted);
      if (emitted) awaited_verdicts.push_back(typed ? want : predicted);
   endtask

   task automatic add_row(input logic [7:0] c, input logic l, input bit typed,
                          input result_type want);
      word_row_type row;
      row.ch    = c;
      row.last  = l;
      row.typed = typed;
      row.want  = want;
      directed_words.push_back(row);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'(CHAR_0 + nib) : 8'(CHAR_A + nib - 8'd10);
   endfunction

   task automatic compose_sentence();
      int         shape;
      int         n;
      int         variant;
      int         line_end;
      logic [7:0] sum;
      logic [7:0] shown;
      logic [7:0] c;
      string      tag;
      line_buf.delete();
      shape = $urandom_range(0, 99);
      if (shape < 10) begin
         // raw noise
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 6);
         repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (shape < 18) begin
         // short runs of framing characters
         n = $urandom_range(1, 5);
         repeat (n) begin
            case ($urandom_range(0, 4))
               0: c = "$";
               1: c = CHAR_STAR;
               2: c = CHAR_CR;
               3: c = CHAR_LF;
               default: c = CHAR_0;
            endcase
            line_buf.push_back(c);
         end
      end else begin
         line_buf.push_back("$");
         repeat (2) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
         case ($urandom_range(0, 7))
            0: tag = "RMC";
            1: tag = "GGA";
            2: tag = "GSV";
            3: tag = "TXT,02,01,02";
            4: tag = "TXT,02,01,0";
            5: tag = "GSA";
            6: tag = "RMB";
            default: tag = "";
         endcase
         for (int i = 0; i < tag.len(); i++) line_buf.push_back(tag[i]);
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
         repeat (n) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            if (c == CHAR_STAR) c = ",";
            line_buf.push_back(c);
         end
         sum = 8'h00;
         for (int i = 1; i < line_buf.size(); i++) sum ^= line_buf[i];
         variant = $urandom_range(0, 99);
         shown   = (variant < 8) ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum;
         if (variant < 94) begin
            line_buf.push_back(CHAR_STAR);
            if (variant < 60) begin
               line_buf.push_back(hex_char(shown[7:4]));
               line_buf.push_back(hex_char(shown[3:0]));
            end else if (variant < 66) begin
               // lower-case digits
               c = hex_char(shown[7:4]);
               line_buf.push_back(c >= CHAR_A ? c + 8'h20 : c);
               c = hex_char(shown[3:0]);
               line_buf.push_back(c >= CHAR_A ? c + 8'h20 : c);
            end else if (variant < 72) begin
               line_buf.push_back(CHAR_0);
               if (shown[7:4] != 4'h0 || $urandom_range(0, 1)) begin
                  line_buf.push_back(hex_char(shown[7:4]));
               end
               line_buf.push_back(hex_char(shown[3:0]));
            end else if (variant < 77) begin
               line_buf.push_back(hex_char(4'($urandom_range(1, 15))));
               line_buf.push_back(hex_char(shown[7:4]));
               line_buf.push_back(hex_char(shown[3:0]));
            end else if (variant < 82) begin
               // empty checksum field
            end else if (variant < 87) begin
               line_buf.push_back(hex_char(shown[7:4]));
               line_buf.push_back(8'($urandom_range(0, 255)));
               line_buf.push_back(hex_char(shown[3:0]));
            end else begin
               line_buf.push_back(hex_char(shown[7:4]));
               line_buf.push_back(hex_char(shown[3:0]));
            end
         end
         line_end = $urandom_range(0, 7);
         if (line_end == 1 || line_end > 2) line_buf.push_back(CHAR_CR);
         if (line_end >= 2) line_buf.push_back(CHAR_LF);
         if (variant >= 87 && variant < 94) begin
            // overlong tail after the star
            repeat ($urandom_range(26, 34)) line_buf.push_back(8'($urandom_range(0, 255)));
         end else if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 15) == 0) begin
         line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(1, line_buf.size());
         while (line_buf.size() > n) void'(line_buf.pop_back());
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (rsp_tvalid === 1'b1 && rsp_tready) begin
         if (awaited_verdicts.size() == 0) begin
            $display("%0t unexpected word: kind %0d ok %0b xor %h", $time,
                     rsp_tuser, rsp_tdata[0], rsp_tdata[8:1]);
            check_failed = 1'b1;
         end else begin
            want = awaited_verdicts.pop_front();
            if (rsp_tuser !== want.sentence_kind) begin
               $display("%0t sentence_kind: expected %0d actual %0d", $time,
                        want.sentence_kind, rsp_tuser);
               check_failed = 1'b1;
            end
            if (rsp_tdata[0] !== want.checksum_ok) begin
               $display("%0t checksum_ok: expected %0b actual %0b", $time,
                        want.checksum_ok, rsp_tdata[0]);
               check_failed = 1'b1;
            end
            if (rsp_tdata[8:1] !== want.xor_sum) begin
               $display("%0t xor_sum: expected %h actual %h", $time,
                        want.xor_sum, rsp_tdata[8:1]);
               check_failed = 1'b1;
            end
         end
      end
   end

   initial begin : result_sink
      int hold;
      int calm_left;
      int taken;
      calm_left = 0;
      taken     = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == 8 || taken == 35) begin
            // long hold so the input backs up
            hold = 400;
         end else if (calm_left > 0) begin
            calm_left--;
            hold = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(4, 12);
            hold      = 0;
         end else begin
            hold = $urandom_range(0, 17);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
         taken++;
      end
   end

   initial begin : stimulus
      int words_sent;
      int sentences_sent;
      int gap;
      bit burst;
      words_sent     = 0;
      sentences_sent = 0;
      clear_sentence_state();

      // lone dollar
      add_row("$", 1'b1, 1'b1, {KIND_OTHER, 1'b0, 8'h00});
      // star at index 1 is data, ends right on the real star
      add_row("$", 1'b0, 1'b0, '0);
      add_row(CHAR_STAR, 1'b0, 1'b0, '0);
      add_row(CHAR_STAR, 1'b1, 1'b1, {KIND_OTHER, 1'b0, 8'h2A});
      // zero byte, empty checksum field
      add_row("$", 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b0, '0);
      add_row(CHAR_STAR, 1'b0, 1'b0, '0);
      add_row(CHAR_CR, 1'b1, 1'b1, {KIND_OTHER, 1'b1, 8'h00});
      // all-ones byte
      add_row("$", 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b0, '0);
      add_row(CHAR_STAR, 1'b0, 1'b0, '0);
      add_row(CHAR_F, 1'b0, 1'b0, '0);
      add_row(CHAR_F, 1'b1, 1'b1, {KIND_OTHER, 1'b1, 8'hFF});
      // checksum value above 255
      add_row("$", 1'b0, 1'b0, '0);
      add_row(CHAR_A, 1'b0, 1'b0, '0);
      add_row(CHAR_STAR, 1'b0, 1'b0, '0);
      add_row("1", 1'b0, 1'b0, '0);
      add_row(CHAR_0, 1'b0, 1'b0, '0);
      add_row(CHAR_0, 1'b1, 1'b1, {KIND_OTHER, 1'b0, 8'h41});
      // tag that just fits
      add_row("$", 1'b0, 1'b0, '0);
      add_row("G", 1'b0, 1'b0, '0);
      add_row("P", 1'b0, 1'b0, '0);
      add_row("R", 1'b0, 1'b0, '0);
      add_row("M", 1'b0, 1'b0, '0);
      add_row("C", 1'b1, 1'b0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[i]) begin
         offer_word(directed_words[i].ch, directed_words[i].last, directed_words[i].typed,
                    directed_words[i].want, $urandom_range(0, 17), 1'b0);
      end

      while (words_sent < 950 || sentences_sent < 60) begin
         compose_sentence();
         burst = ($urandom_range(0, 3) == 0);
         foreach (line_buf[i]) begin
            gap = burst ? 0 : $urandom_range(0, 17);
            offer_word(line_buf[i], i == line_buf.size() - 1, 1'b0, '0, gap,
                       i == 0 && sentences_sent % 20 == 10);
         end
         words_sent += line_buf.size();
         sentences_sent++;
      end

      req_tvalid <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!check_failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
